/* sv/ssnf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and digit helpers for the seven-segment number formatter.
package ssnf_pkg;

  localparam int DIGIT_COUNT = 6;

  typedef enum logic [2:0] {
    CMD_PLAIN  = 3'd0,
    CMD_DOUBLE = 3'd1,
    CMD_COMMA  = 3'd2,
    CMD_BLINK  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_ALL_ON = 3'd5,
    CMD_READ   = 3'd6
  } cmd_e;

  typedef logic [3:0] bcd_t;
  typedef logic [9:0] grp_t;
  typedef logic [7:0] seg_t;

  // floor(n / 10^6) = (n * RECIP_1E6) >> SHIFT_1E6 holds exactly for every 32-bit n.
  localparam logic [30:0] RECIP_1E6 = 31'd1125899907;
  localparam int          SHIFT_1E6 = 50;
  localparam logic [19:0] MOD_1E6   = 20'd1000000;
  // floor(n / 1000) = (n * RECIP_1E3) >> SHIFT_1E3 holds exactly for n below 6.1 million.
  localparam logic [19:0] RECIP_1E3 = 20'd536871;
  localparam int          SHIFT_1E3 = 29;
  localparam logic [9:0]  MOD_1E3   = 10'd1000;

  localparam seg_t SEG_DARK  = 8'h00;
  localparam seg_t SEG_ALL   = 8'hFF;
  localparam seg_t SEG_POINT = 8'h80;

  // Four three-digit groups: both values split at the thousands.
  typedef struct packed {
    cmd_e cmd;
    grp_t m_hi;
    grp_t m_lo;
    grp_t s_hi;
    grp_t s_lo;
  } groups_t;

  typedef struct packed {
    cmd_e                   cmd;
    bcd_t [DIGIT_COUNT-1:0] mdig;
    bcd_t [DIGIT_COUNT-1:0] sdig;
  } digits_t;

  typedef struct packed {
    bcd_t       hund;
    logic [6:0] rest;
  } hsplit_t;

  typedef struct packed {
    bcd_t tens;
    bcd_t units;
  } tsplit_t;

  function automatic seg_t seg_encode(input bcd_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7C;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_DARK;
    endcase
    return s;
  endfunction

  // Hundreds digit of a value below 1000 by a compare ladder.
  function automatic hsplit_t split_hundreds(input grp_t x);
    hsplit_t r;
    r.hund = 4'd0;
    r.rest = 7'(x);
    for (int k = 1; k < 10; k++) begin
      if (x >= 10'(k * 100)) begin
        r.hund = 4'(k);
        r.rest = 7'(x - 10'(k * 100));
      end
    end
    return r;
  endfunction

  // Tens and units of a value below 100.
  function automatic tsplit_t split_tens(input logic [6:0] x);
    tsplit_t r;
    r.tens  = 4'd0;
    r.units = 4'(x);
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(k * 10)) begin
        r.tens  = 4'(k);
        r.units = 4'(x - 7'(k * 10));
      end
    end
    return r;
  endfunction

endpackage

/* sv/seven_segment_number_formatter_core.sv */
`timescale 1ns / 1ps
// Top level of the seven-segment number formatter.
//
// Usage: an input transaction carries a command (plain, double, comma, blink,
// clear, all on, read) and up to two unsigned values. Each transaction yields
// exactly one result transaction with the six segment bytes (leftmost digit in
// the top byte, bit 7 of each byte the decimal point), the sticky blink flag and
// the number last shown, which is -1 after reset, clear or all on.
// Both channels use valid/ready. The block is a ten-register pipeline: the
// accepted transaction sits in the input register, four stages of
// reciprocal multiplies split the values into three-digit groups, two stages
// form decimal digits, two stages place and encode the digits, and the last
// register holds the display state and the result.
// Throughput: one transaction per cycle while results are taken; the 32 x 31 bit
// multiply that reduces the first value modulo one million sets the length of the
// first stage. Each stage holds its data while the stage after it is full, so
// input is still taken while a result waits for the receiver, until the pipeline
// is full. Reset clears the display to dark, the shown number to -1 and
// the blink flag.
module seven_segment_number_formatter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic [31:0]        first_value_i,
  input  logic [16:0]        second_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [47:0]        segment_pattern_o,
  output logic               blink_on_o,
  output logic signed [32:0] shown_value_o
);

  logic              grp_valid;
  logic              grp_ready;
  ssnf_pkg::groups_t groups;
  logic              dig_valid;
  logic              dig_ready;
  ssnf_pkg::digits_t digits;
  logic              digits_ok;

  ssnf_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .cmd_i    (ssnf_pkg::cmd_e'(cmd_i)),
    .first_i  (first_value_i),
    .second_i (second_value_i),
    .valid_o  (grp_valid),
    .ready_i  (grp_ready),
    .groups_o (groups)
  );

  ssnf_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (grp_valid),
    .ready_o  (grp_ready),
    .groups_i (groups),
    .valid_o  (dig_valid),
    .ready_i  (dig_ready),
    .digits_o (digits)
  );

  ssnf_fmt u_fmt (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (dig_valid),
    .ready_o           (dig_ready),
    .digits_i          (digits),
    .valid_o           (out_valid_o),
    .ready_i           (out_ready_i),
    .segment_pattern_o (segment_pattern_o),
    .blink_on_o        (blink_on_o),
    .shown_value_o     (shown_value_o)
  );

  always_comb begin
    digits_ok = 1'b1;
    for (int p = 0; p < ssnf_pkg::DIGIT_COUNT; p++) begin
      if (digits.mdig[p] > 4'd9 || digits.sdig[p] > 4'd9) begin
        digits_ok = 1'b0;
      end
    end
  end

  // The reciprocal multiplies must leave every group below one thousand.
  a_groups_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid |-> (groups.m_hi < 10'd1000 && groups.m_lo < 10'd1000 &&
                   groups.s_hi < 10'd1000 && groups.s_lo < 10'd1000))
    else $error("three-digit group out of range");

  a_digits_decimal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_valid |-> digits_ok)
    else $error("digit above nine after conversion");

  a_blink_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_on_o |=> blink_on_o)
    else $error("blink flag dropped");

  a_shown_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (shown_value_o == -33'sd1 || shown_value_o < 33'sd1000000))
    else $error("shown number exceeds six digits");

endmodule

/* sv/ssnf_split.sv */
`timescale 1ns / 1ps
// Input register and reciprocal-multiply pipeline that splits both values into 3-digit groups.
module ssnf_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  ssnf_pkg::cmd_e      cmd_i,
  input  logic [31:0]         first_i,
  input  logic [16:0]         second_i,
  output logic                valid_o,
  input  logic                ready_i,
  output ssnf_pkg::groups_t   groups_o
);

  localparam int STAGES = 5;
  localparam int QW     = 13;

  logic [STAGES-1:0] vld_q;
  logic [STAGES:0]   rdy;

  // Stage 0: accepted transaction.
  ssnf_pkg::cmd_e cmd0_q;
  logic [31:0]    first0_q;
  logic [16:0]    second0_q;
  // Stage 1: quotients by 10^6 and by 1000.
  ssnf_pkg::cmd_e cmd1_q;
  logic [19:0]    flo1_q;
  logic [16:0]    sec1_q;
  logic [QW-1:0]  q1_q;
  logic [7:0]     shi1_q;
  // Stage 2: first value mod 10^6, second value split.
  ssnf_pkg::cmd_e  cmd2_q;
  logic [19:0]     m2_q;
  logic [7:0]      shi2_q;
  ssnf_pkg::grp_t  slo2_q;
  // Stage 3: upper group of the first value.
  ssnf_pkg::cmd_e  cmd3_q;
  logic [19:0]     m3_q;
  ssnf_pkg::grp_t  mhi3_q;
  logic [7:0]      shi3_q;
  ssnf_pkg::grp_t  slo3_q;
  // Stage 4: all groups.
  ssnf_pkg::groups_t groups4_q;

  logic [62:0]       prod1;
  logic [36:0]       prod_s;
  logic [32:0]       qm;
  logic [16:0]       shm;
  logic [39:0]       prod3;
  logic [19:0]       mm;
  logic [QW-1:0]     q1_d;
  logic [7:0]        shi1_d;
  logic [19:0]       m2_d;
  ssnf_pkg::grp_t    slo2_d;
  ssnf_pkg::grp_t    mhi3_d;
  ssnf_pkg::groups_t groups4_d;

  always_comb begin
    rdy[STAGES] = ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign ready_o  = rdy[0];
  assign valid_o  = vld_q[STAGES-1];
  assign groups_o = groups4_q;

  always_comb begin
    prod1  = 63'(first0_q) * 63'(ssnf_pkg::RECIP_1E6);
    q1_d   = prod1[ssnf_pkg::SHIFT_1E6 +: QW];
    prod_s = 37'(second0_q) * 37'(ssnf_pkg::RECIP_1E3);
    shi1_d = prod_s[ssnf_pkg::SHIFT_1E3 +: 8];

    // The remainder is below 2^20, so the low 20 bits of the product suffice.
    qm     = 33'(q1_q) * 33'(ssnf_pkg::MOD_1E6);
    m2_d   = flo1_q - qm[19:0];
    shm    = 17'(shi1_q) * 17'(ssnf_pkg::MOD_1E3);
    slo2_d = 10'(sec1_q - shm);

    prod3  = 40'(m2_q) * 40'(ssnf_pkg::RECIP_1E3);
    mhi3_d = prod3[ssnf_pkg::SHIFT_1E3 +: 10];

    mm             = 20'(mhi3_q) * 20'(ssnf_pkg::MOD_1E3);
    groups4_d.cmd  = cmd3_q;
    groups4_d.m_hi = mhi3_q;
    groups4_d.m_lo = 10'(m3_q - mm);
    groups4_d.s_hi = 10'(shi3_q);
    groups4_d.s_lo = slo3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cmd0_q    <= cmd_i;
      first0_q  <= first_i;
      second0_q <= second_i;
    end
    if (rdy[1]) begin
      cmd1_q <= cmd0_q;
      flo1_q <= first0_q[19:0];
      sec1_q <= second0_q;
      q1_q   <= q1_d;
      shi1_q <= shi1_d;
    end
    if (rdy[2]) begin
      cmd2_q <= cmd1_q;
      m2_q   <= m2_d;
      shi2_q <= shi1_q;
      slo2_q <= slo2_d;
    end
    if (rdy[3]) begin
      cmd3_q <= cmd2_q;
      m3_q   <= m2_q;
      mhi3_q <= mhi3_d;
      shi3_q <= shi2_q;
      slo3_q <= slo2_q;
    end
    if (rdy[4]) begin
      groups4_q <= groups4_d;
    end
  end

endmodule

/* sv/ssnf_bcd.sv */
`timescale 1ns / 1ps
// Two-stage conversion of the four 3-digit groups into decimal digits.
module ssnf_bcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ssnf_pkg::groups_t groups_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ssnf_pkg::digits_t digits_o
);

  logic [1:0] vld_q;
  logic [2:0] rdy;

  ssnf_pkg::cmd_e             cmda_q;
  ssnf_pkg::hsplit_t [3:0]    hs_q;
  ssnf_pkg::hsplit_t [3:0]    hs_d;
  ssnf_pkg::grp_t [3:0]       grp;
  ssnf_pkg::tsplit_t [3:0]    ts;
  ssnf_pkg::digits_t          digits_d;
  ssnf_pkg::digits_t          digits_q;

  always_comb begin
    rdy[2] = ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign ready_o  = rdy[0];
  assign valid_o  = vld_q[1];
  assign digits_o = digits_q;

  always_comb begin
    grp = {groups_i.m_hi, groups_i.m_lo, groups_i.s_hi, groups_i.s_lo};
    for (int g = 0; g < 4; g++) begin
      hs_d[g] = ssnf_pkg::split_hundreds(grp[g]);
    end
  end

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      ts[g] = ssnf_pkg::split_tens(hs_q[g].rest);
    end
    digits_d.cmd  = cmda_q;
    digits_d.mdig = {hs_q[3].hund, ts[3].tens, ts[3].units,
                     hs_q[2].hund, ts[2].tens, ts[2].units};
    digits_d.sdig = {hs_q[1].hund, ts[1].tens, ts[1].units,
                     hs_q[0].hund, ts[0].tens, ts[0].units};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cmda_q <= groups_i.cmd;
      hs_q   <= hs_d;
    end
    if (rdy[1]) begin
      digits_q <= digits_d;
    end
  end

endmodule

/* sv/ssnf_fmt.sv */
`timescale 1ns / 1ps
// Digit placement, blanking and segment encoding, then the display state and result register.
module ssnf_fmt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  ssnf_pkg::digits_t      digits_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [47:0]            segment_pattern_o,
  output logic                   blink_on_o,
  output logic signed [32:0]     shown_value_o
);

  localparam int DC = ssnf_pkg::DIGIT_COUNT;

  typedef struct packed {
    logic write;
    logic no_number;
    logic set_blink;
  } fmt_ctrl_t;

  logic [1:0] vld_q;
  logic [2:0] rdy;
  logic       out_vld_q;

  // Stage 1 results.
  ssnf_pkg::bcd_t [DC-1:0]  num_d;
  ssnf_pkg::seg_t [DC-1:0]  bytes_d;
  fmt_ctrl_t                ctrl_d;
  ssnf_pkg::bcd_t [DC-1:0]  num1_q;
  ssnf_pkg::seg_t [DC-1:0]  bytes1_q;
  fmt_ctrl_t                ctrl1_q;
  // Stage 2 results: digit pairs as binary.
  logic [2:0][6:0]          pair_d;
  logic [2:0][6:0]          pair2_q;
  ssnf_pkg::seg_t [DC-1:0]  bytes2_q;
  fmt_ctrl_t                ctrl2_q;
  // Display state, which is also the result register.
  ssnf_pkg::seg_t [DC-1:0]  bytes_q;
  logic signed [32:0]       number_q;
  logic                     blink_q;

  logic [19:0]     value;
  logic [2:0]      frac_len;
  logic [DC-1:0]   point;
  logic [DC-1:0]   nz;
  logic [DC-1:0]   lit;
  logic            dbl;
  logic            fill_dark;
  logic            fill_all;

  always_comb begin
    rdy[2] = !out_vld_q || ready_i;
    rdy[1] = !vld_q[1] || rdy[2];
    rdy[0] = !vld_q[0] || rdy[1];
  end

  assign ready_o = rdy[0];

  // Stage 1: choose the digits for the command and build the segment bytes.
  always_comb begin
    // A zero fraction still takes one digit.
    frac_len = 3'd1;
    for (int k = 1; k < DC - 1; k++) begin
      if (digits_i.sdig[k] != 4'd0) begin
        frac_len = 3'(k + 1);
      end
    end

    num_d     = digits_i.mdig;
    point     = '0;
    dbl       = 1'b0;
    fill_dark = 1'b0;
    fill_all  = 1'b0;
    ctrl_d    = '0;

    unique case (digits_i.cmd) inside
      ssnf_pkg::CMD_PLAIN, ssnf_pkg::CMD_BLINK: begin
        ctrl_d.write     = 1'b1;
        ctrl_d.set_blink = (digits_i.cmd == ssnf_pkg::CMD_BLINK);
      end
      ssnf_pkg::CMD_DOUBLE: begin
        num_d        = {digits_i.mdig[2:0], digits_i.sdig[2:0]};
        point[3]     = 1'b1;
        dbl          = 1'b1;
        ctrl_d.write = 1'b1;
      end
      ssnf_pkg::CMD_COMMA: begin
        // Integer digits move up by the fraction length; the top ones fall off.
        for (int p = 0; p < DC; p++) begin
          if (p < int'(frac_len)) begin
            num_d[p] = digits_i.sdig[p];
          end else begin
            num_d[p] = digits_i.mdig[3'(p - int'(frac_len))];
          end
        end
        point[frac_len] = 1'b1;
        ctrl_d.write    = 1'b1;
      end
      ssnf_pkg::CMD_CLEAR: begin
        fill_dark        = 1'b1;
        ctrl_d.write     = 1'b1;
        ctrl_d.no_number = 1'b1;
      end
      ssnf_pkg::CMD_ALL_ON: begin
        fill_all         = 1'b1;
        ctrl_d.write     = 1'b1;
        ctrl_d.no_number = 1'b1;
      end
      default: begin
        ctrl_d.write = 1'b0;
      end
    endcase

    for (int p = 0; p < DC; p++) begin
      nz[p] = (num_d[p] != 4'd0);
    end

    // A digit is lit if any digit at or above it in its group is nonzero;
    // the lowest digit of each group is always lit.
    for (int p = 0; p < DC; p++) begin
      lit[p] = (p == 0) || (dbl && p == 3);
      for (int q = 0; q < DC; q++) begin
        if (q >= p && (!dbl || ((q < 3) == (p < 3)))) begin
          lit[p] = lit[p] | nz[q];
        end
      end
    end

    for (int p = 0; p < DC; p++) begin
      if (fill_dark) begin
        bytes_d[p] = ssnf_pkg::SEG_DARK;
      end else if (fill_all) begin
        bytes_d[p] = ssnf_pkg::SEG_ALL;
      end else begin
        bytes_d[p] = (lit[p] ? ssnf_pkg::seg_encode(num_d[p]) : ssnf_pkg::SEG_DARK)
                   | (point[p] ? ssnf_pkg::SEG_POINT : ssnf_pkg::SEG_DARK);
      end
    end
  end

  // Stage 2: pairs of digits to binary.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pair_d[i] = 7'(num1_q[2*i+1]) * 7'd10 + 7'(num1_q[2*i]);
    end
  end

  assign value = 20'(pair2_q[2]) * 20'd10000 + 20'(pair2_q[1]) * 20'd100 + 20'(pair2_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      bytes_q   <= '0;
      number_q  <= '1;
      blink_q   <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= valid_i;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
      if (rdy[2]) begin
        out_vld_q <= vld_q[1];
        // Every command either rewrites the whole display or leaves it alone,
        // so the state is updated only here, in transaction order.
        if (vld_q[1] && ctrl2_q.write) begin
          bytes_q  <= bytes2_q;
          number_q <= ctrl2_q.no_number ? '1 : 33'(value);
        end
        if (vld_q[1] && ctrl2_q.set_blink) begin
          blink_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      num1_q   <= num_d;
      bytes1_q <= bytes_d;
      ctrl1_q  <= ctrl_d;
    end
    if (rdy[1]) begin
      pair2_q  <= pair_d;
      bytes2_q <= bytes1_q;
      ctrl2_q  <= ctrl1_q;
    end
  end

  assign valid_o           = out_vld_q;
  assign segment_pattern_o = bytes_q;
  assign blink_on_o        = blink_q;
  assign shown_value_o     = number_q;

endmodule
